[hdl/assert_macros.svh]
// Assertion macros for the matcher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent this cycle implies consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/spm_pkg.sv]
// Types and constants for the substring presence matcher.
package spm_pkg;

  // Default pattern capacity in bytes
  localparam int MAX_PATTERN_DEF = 32;

  // Word kinds
  localparam logic OP_PATTERN = 1'b0;
  localparam logic OP_TEXT    = 1'b1;

  // Byte that ends a pattern early
  localparam logic [7:0] END_BYTE = 8'h00;

  typedef struct packed {
    logic       op;
    logic [7:0] byte_value;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic found;
    logic overflow;
  } out_word_t;

  // Per-cell controls from the sequencer
  typedef struct packed {
    logic load;   // capture the incoming byte as pattern byte
    logic shift;  // advance the match bit with the incoming text byte
    logic clear;  // drop the match bit
  } cell_ctrl_t;

endpackage

[hdl/substring_presence_matcher_core.sv]
// Top level of the substring presence matcher: sequencer, cell chain, result register.
//
// Usage: words enter on in_data with in_valid/in_stall. A word with op = pattern
// carries one pattern byte; a zero byte ends the pattern early, and last = 1
// closes it. A pattern word after a closed pattern starts a new pattern. Words
// with op = text stream the text; the word with last = 1 ends the text.
// One result word (found, overflow) leaves on out_data with out_valid/out_stall
// for every text word with last = 1; other words give no result.
// Each of the MAX_PATTERN cells holds one pattern byte and one partial-match
// bit and compares its byte against the text byte in parallel, so one word is
// taken every cycle unless in_stall is high. The result appears in the cycle after
// its last text word. The result register lets the next word enter while a result
// is being taken; only when a result waits and out_stall is high does in_stall go high.
// Reset (rst, synchronous) empties the pattern and the search state and drops
// any pending result. A pattern longer than MAX_PATTERN sets overflow and
// reports not found; an empty pattern is always found.
`include "assert_macros.svh"

module substring_presence_matcher_core
  import spm_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN);

  logic [LEN_W-1:0] len, len_next;
  logic             closed, closed_next;
  logic             ended, ended_next;
  logic             overflow, overflow_next;
  logic             found, found_next;

  logic             accept;
  logic             is_text;
  logic             restart;
  logic [LEN_W-1:0] len_eff;
  logic             ended_eff;
  logic             pat_write;
  logic             search_clear;
  logic             hit;
  logic             found_acc;
  logic             result_load;
  logic [IDX_W-1:0] hit_idx;

  logic [MAX_PATTERN-1:0] match_q;
  logic [MAX_PATTERN-1:0] match_nx;

  // Handshake
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_text  = (in_data.op == OP_TEXT);

  // Pattern word after a closed pattern starts over
  assign restart   = !is_text && closed;
  assign len_eff   = restart ? '0 : len;
  assign ended_eff = restart ? 1'b0 : ended;
  assign pat_write = accept && !is_text && !ended_eff &&
                     (in_data.byte_value != END_BYTE) && (len_eff != LEN_MAX);

  // Search state clears on a new pattern and after the end of text
  assign search_clear = accept && ((restart) || (is_text && in_data.last));

  // Tail cell of the pattern decides a hit
  assign hit_idx   = IDX_W'(len - LEN_W'(1));
  assign hit       = (len == '0) || match_nx[hit_idx];
  assign found_acc = found || hit;

  assign result_load = accept && is_text && in_data.last;

  // Cell chain
  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    cell_ctrl_t ctrl;
    logic       link;

    assign ctrl.load  = pat_write && (len_eff == LEN_W'(i));
    assign ctrl.shift = accept && is_text && (LEN_W'(i) < len);
    assign ctrl.clear = search_clear;

    if (i == 0) begin : g_head
      assign link = 1'b1;
    end else begin : g_link
      assign link = match_q[i-1];
    end

    spm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .data     (in_data.byte_value),
      .match_in (link),
      .match_q  (match_q[i]),
      .match_nx (match_nx[i])
    );
  end

  // Sequencer next state
  always_comb begin
    len_next      = len;
    closed_next   = closed;
    ended_next    = ended;
    overflow_next = overflow;
    found_next    = found;
    if (accept) begin
      if (!is_text) begin
        len_next      = len_eff;
        ended_next    = ended_eff;
        overflow_next = restart ? 1'b0 : overflow;
        found_next    = restart ? 1'b0 : found;
        if (!ended_eff) begin
          if (in_data.byte_value == END_BYTE) begin
            ended_next = 1'b1;
          end else if (len_eff != LEN_MAX) begin
            len_next = len_eff + LEN_W'(1);
          end else begin
            overflow_next = 1'b1;
          end
        end
        closed_next = in_data.last;
      end else begin
        closed_next = 1'b1;
        found_next  = in_data.last ? 1'b0 : found_acc;
      end
    end
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      len      <= '0;
      closed   <= 1'b0;
      ended    <= 1'b0;
      overflow <= 1'b0;
      found    <= 1'b0;
    end else begin
      len      <= len_next;
      closed   <= closed_next;
      ended    <= ended_next;
      overflow <= overflow_next;
      found    <= found_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      out_data.found    <= found_acc && !overflow;
      out_data.overflow <= overflow;
    end
  end

  // Checks
  `ASSERT_ALWAYS(a_len_bound, len <= LEN_MAX, "pattern length beyond capacity")
  `ASSERT_ALWAYS(a_ovf_full, !overflow || (len == LEN_MAX), "overflow with room left")
  `ASSERT_ALWAYS(a_ovf_not_found, !out_valid || !(out_data.found && out_data.overflow),
                 "found reported with overflow")
  `ASSERT_NEXT(a_result_follows, result_load, out_valid, "end of text gave no result")

endmodule

[hdl/spm_cell.sv]
// One matcher cell: a pattern byte and the partial-match bit that ends on it.
module spm_cell
  import spm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  logic [7:0] data,
  input  logic       match_in,
  output logic       match_q,
  output logic       match_nx
);

  logic [7:0] pat;

  // Prefix matched up to the left neighbor and this byte agrees
  assign match_nx = match_in && (pat == data);

  // Pattern byte storage
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      pat <= data;
    end
  end

  // Partial-match bit, handed to the right neighbor
  always_ff @(posedge clk) begin
    if (rst) begin
      match_q <= 1'b0;
    end else if (ctrl.clear) begin
      match_q <= 1'b0;
    end else if (ctrl.shift) begin
      match_q <= match_nx;
    end
  end

endmodule
